// File: src/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg: shared types and constants for the max-heap priority queue
// Record layout, index widths and status codes.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  // child indices can run past the depth before the bound check
  localparam int IDX_W      = ADDR_W + 2;

  localparam int KEY_W = 16;
  localparam int PAY_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] order;
    logic [PAY_W-1:0] client;
    logic [PAY_W-1:0] amount;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

endpackage

// File: src/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap of delivery records
// Insert sifts up, extract returns the largest key and sifts down.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | into      | in_valid / in_ready  | operation, key, order, client, amount
//  out_    | out of    | out_valid / out_ready| status, record, entry total
//
//  A refused op (full or empty) goes straight to the output state S_FIN. An insert
//  climbs through S_UP_RD and S_UP_CMP per level; an extract reads the root and
//  last slot in S_DN_LOAD, then descends through S_DN_RD and S_DN_CMP per level,
//  and goes straight to S_FIN when it empties the heap.
//  Each heap level costs a RAM read state plus a compare/write state.
//  Reset clears the fill count and control; RAM contents are not cleared.
//  A stalled output beat holds the finished op in its last state; the next
//  beat is taken as soon as the result moves into the output register.
//
module max_heap_priority_queue (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [15:0]               in_delivery_time,
  input  logic [31:0]               in_order_id,
  input  logic [31:0]               in_client_code,
  input  logic [31:0]               in_amount_bits,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [15:0]               out_time,
  output logic [31:0]               out_order,
  output logic [31:0]               out_client,
  output logic [31:0]               out_amount,
  output logic [hpq_pkg::CNT_W-1:0] out_entry_total
);
  import hpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,    // issue parent read, or settle at the root
    S_UP_CMP,   // compare carried key against parent
    S_DN_LOAD,  // root and last slot arrive
    S_DN_RD,    // issue child reads
    S_DN_CMP,   // pick the larger child
    S_FIN       // hand result to output register
  } state_t;

  state_t  state_r, state_nxt;
  cnt_t    count_r, count_nxt;
  addr_t   pos_r, pos_nxt;
  rec_t    carry_r, carry_nxt;     // record being sifted (the "hole" value)
  rec_t    res_rec_r, res_rec_nxt; // extracted record, zero otherwise
  status_t res_st_r, res_st_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_st_r, out_st_nxt;
  rec_t    out_rec_r, out_rec_nxt;
  cnt_t    out_cnt_r, out_cnt_nxt;

  // RAM port
  logic    we;
  addr_t   waddr, raddr0, raddr1;
  rec_t    wdata, rdata0, rdata1;

  hpq_ram u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  rec_t  in_rec;
  logic  in_beat;
  addr_t parent;
  idx_t  lc, rc, cnt_x;
  logic  lc_ok, rc_ok;
  logic  take_l, take_r;
  logic [KEY_W-1:0] best_key;

  assign in_rec   = '{key: in_delivery_time, order: in_order_id,
                      client: in_client_code, amount: in_amount_bits};
  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  assign parent = addr_t'((pos_r - addr_t'(1)) >> 1);
  assign lc     = {1'b0, pos_r, 1'b1};
  assign rc     = idx_t'({1'b0, pos_r, 1'b0} + idx_t'(2));
  assign cnt_x  = idx_t'(count_r);
  assign lc_ok  = (lc < cnt_x);
  assign rc_ok  = (rc < cnt_x);

  // left wins ties: right must beat the best so far strictly
  always_comb begin
    take_l   = lc_ok && (rdata0.key > carry_r.key);
    best_key = take_l ? rdata0.key : carry_r.key;
    take_r   = rc_ok && (rdata1.key > best_key);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    carry_nxt     = carry_r;
    res_rec_nxt   = res_rec_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_rec_nxt   = out_rec_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = carry_r;
    raddr0        = parent;
    raddr1        = parent;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          res_rec_nxt = '0;
          state_nxt   = S_FIN;
          if (op_t'(in_operation) == OP_INSERT) begin
            if (count_r == cnt_t'(HEAP_DEPTH)) begin
              res_st_nxt = ST_FULL;
            end else begin
              res_st_nxt = ST_INSERTED;
              carry_nxt  = in_rec;
              pos_nxt    = count_r[ADDR_W-1:0];
              count_nxt  = count_r + cnt_t'(1);
              state_nxt  = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = ST_EMPTY;
            end else begin
              res_st_nxt = ST_EXTRACTED;
              raddr0     = '0;
              raddr1     = addr_t'(count_r - cnt_t'(1));
              count_nxt  = count_r - cnt_t'(1);
              state_nxt  = S_DN_LOAD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (carry_r.key > rdata0.key) begin
          wdata     = rdata0;       // parent drops into the hole
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DN_LOAD: begin
        res_rec_nxt = rdata0;
        carry_nxt   = rdata1;
        pos_nxt     = '0;
        state_nxt   = (count_r == '0) ? S_FIN : S_DN_RD;
      end

      S_DN_RD: begin
        raddr0 = lc[ADDR_W-1:0];
        raddr1 = rc[ADDR_W-1:0];
        if (!lc_ok) begin
          we        = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata     = rdata1;
          pos_nxt   = rc[ADDR_W-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          wdata     = rdata0;
          pos_nxt   = lc[ADDR_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_rec_nxt   = res_rec_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    carry_r   <= carry_nxt;
    res_rec_r <= res_rec_nxt;
    res_st_r  <= res_st_nxt;
    out_st_r  <= out_st_nxt;
    out_rec_r <= out_rec_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_time        = out_rec_r.key;
  assign out_order       = out_rec_r.order;
  assign out_client      = out_rec_r.client;
  assign out_amount      = out_rec_r.amount;
  assign out_entry_total = out_cnt_r;

endmodule

// File: src/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram: heap record store
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_ram (
  input  logic          clk,
  input  logic          we,
  input  hpq_pkg::addr_t waddr,
  input  hpq_pkg::rec_t wdata,
  input  hpq_pkg::addr_t raddr0,
  input  hpq_pkg::addr_t raddr1,
  output hpq_pkg::rec_t rdata0,
  output hpq_pkg::rec_t rdata1
);
  import hpq_pkg::*;

  rec_t mem [HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
